// ----- hdl/dpcl_pkg.sv -----
// shared types and constants for the dual pi current loop
// register indexes, reset values, datapath widths, config and control bundles
`timescale 1ns / 1ps

package dpcl_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CAP_A  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CAP_B  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDING_RES = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_K    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SUPPLY  = 4'd7;

    localparam logic [15:0] RST_PROP_GAIN   = 16'd0;
    localparam logic [15:0] RST_INTEG_GAIN  = 16'd0;
    localparam logic [14:0] RST_INTEG_LIMIT = 15'd12288;   // 3.0 in q4.12
    localparam logic [15:0] RST_DUTY_CAP    = 16'd65535;
    localparam logic [15:0] RST_WINDING_RES = 16'd512;     // 2.0 ohm in q8.8
    localparam logic [15:0] RST_TORQUE_K    = 16'd737;     // 0.18 in q4.12
    localparam logic [15:0] RST_INV_SUPPLY  = 16'd5461;    // 1/12 in q0.16

    // datapath widths
    localparam int ERR_W   = 17;
    localparam int PROD_W  = 34;
    localparam int VOLT_W  = 36;
    localparam int SPLIT_W = 18;   // low part of the voltage for the duty multiply
    localparam int DUTY_W  = 53;
    localparam int FRAC_SH = 20;   // duty product q.36 down to q0.16

    // pipeline ranks ahead of the output register
    localparam int STAGES = 6;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [14:0] integ_limit;
        logic [15:0] duty_cap_a;
        logic [15:0] duty_cap_b;
        logic [15:0] winding_resistance;
        logic [15:0] torque_constant;
        logic [15:0] inv_supply;
    } cfg_t;

    typedef struct packed {
        logic adv;    // whole pipeline moves one rank
        logic step;   // a real item leaves the input rank, integrator updates
    } pipe_ctrl_t;

endpackage

// ----- hdl/dpcl_regs.sv -----
// configuration register file for the dual pi current loop
// depends on dpcl_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps

module dpcl_regs
    import dpcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:   cfg_next.prop_gain          = cfg_data;
                REG_INTEG_GAIN:  cfg_next.integ_gain         = cfg_data;
                REG_INTEG_LIMIT: cfg_next.integ_limit        = cfg_data[14:0];
                REG_DUTY_CAP_A:  cfg_next.duty_cap_a         = cfg_data;
                REG_DUTY_CAP_B:  cfg_next.duty_cap_b         = cfg_data;
                REG_WINDING_RES: cfg_next.winding_resistance = cfg_data;
                REG_TORQUE_K:    cfg_next.torque_constant    = cfg_data;
                REG_INV_SUPPLY:  cfg_next.inv_supply         = cfg_data;
                default:         cfg_next                    = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain          <= RST_PROP_GAIN;
            cfg_reg.integ_gain         <= RST_INTEG_GAIN;
            cfg_reg.integ_limit        <= RST_INTEG_LIMIT;
            cfg_reg.duty_cap_a         <= RST_DUTY_CAP;
            cfg_reg.duty_cap_b         <= RST_DUTY_CAP;
            cfg_reg.winding_resistance <= RST_WINDING_RES;
            cfg_reg.torque_constant    <= RST_TORQUE_K;
            cfg_reg.inv_supply         <= RST_INV_SUPPLY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/dpcl_channel.sv -----
// one motor channel: error, clamped integrator, feedforward plus pi voltage,
// duty product, rounding and capping; depends on dpcl_pkg
`timescale 1ns / 1ps

module dpcl_channel
    import dpcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pipe_ctrl_t         ctrl,
    input  cfg_t               cfg,
    input  logic [15:0]        duty_cap,
    input  logic signed [15:0] meas_current,
    input  logic signed [15:0] want_current,
    input  logic signed [15:0] speed,
    output logic [15:0]        duty_mag,
    output logic               reverse
);

    // rank 0: input register
    logic signed [15:0] meas_s0_reg;
    logic signed [15:0] want_s0_reg;
    logic signed [15:0] speed_s0_reg;

    // rank 1: error and delayed operands, integrator state
    logic signed [ERR_W-1:0] err_s1_reg;
    logic signed [15:0]      want_s1_reg;
    logic signed [15:0]      speed_s1_reg;
    logic signed [15:0]      integ_reg;
    logic signed [15:0]      integ_next;

    // rank 2: the four products
    logic signed [PROD_W-1:0] prod_res_reg;
    logic signed [PROD_W-1:0] prod_kt_reg;
    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_i_reg;

    // rank 3..5
    logic signed [VOLT_W-1:0] volts_reg;
    logic signed [DUTY_W-1:0] pp_lo_reg;
    logic signed [DUTY_W-1:0] pp_hi_reg;
    logic signed [DUTY_W-1:0] duty_reg;

    // output register
    logic [15:0] duty_mag_reg;
    logic        reverse_reg;

    // integrator update
    logic signed [ERR_W-1:0] err_s0;
    logic signed [17:0]      acc;
    logic signed [17:0]      lim;

    always_comb
    begin
        err_s0 = {want_s0_reg[15], want_s0_reg} - {meas_s0_reg[15], meas_s0_reg};
        acc    = {{2{integ_reg[15]}}, integ_reg} + {err_s0[ERR_W-1], err_s0};
        lim    = {3'b000, cfg.integ_limit};
        priority if (acc > lim)
            integ_next = lim[15:0];
        else if (acc < -lim)
            integ_next = 16'(-lim);
        else
            integ_next = acc[15:0];
    end

    // operands widened to the product width so the products stay exact
    logic signed [PROD_W-1:0] res_x, kt_x, kp_x, ki_x;
    logic signed [PROD_W-1:0] want_x, speed_x, err_x, integ_x;

    always_comb
    begin
        res_x   = {{(PROD_W-16){1'b0}}, cfg.winding_resistance};
        kt_x    = {{(PROD_W-16){1'b0}}, cfg.torque_constant};
        kp_x    = {{(PROD_W-16){1'b0}}, cfg.prop_gain};
        ki_x    = {{(PROD_W-16){1'b0}}, cfg.integ_gain};
        want_x  = {{(PROD_W-16){want_s1_reg[15]}}, want_s1_reg};
        speed_x = {{(PROD_W-16){speed_s1_reg[15]}}, speed_s1_reg};
        err_x   = {{(PROD_W-ERR_W){err_s1_reg[ERR_W-1]}}, err_s1_reg};
        integ_x = {{(PROD_W-16){integ_reg[15]}}, integ_reg};
    end

    logic signed [VOLT_W-1:0] volts_next;

    always_comb
    begin
        volts_next = {{(VOLT_W-PROD_W){prod_res_reg[PROD_W-1]}}, prod_res_reg}
                   + {{(VOLT_W-PROD_W){prod_kt_reg[PROD_W-1]}}, prod_kt_reg}
                   + {{(VOLT_W-PROD_W){prod_p_reg[PROD_W-1]}}, prod_p_reg}
                   + {{(VOLT_W-PROD_W){prod_i_reg[PROD_W-1]}}, prod_i_reg};
    end

    // voltage times reciprocal supply, split into low and high partial products
    logic signed [DUTY_W-1:0] lo_x, hi_x, inv_x;

    always_comb
    begin
        lo_x  = {{(DUTY_W-SPLIT_W){1'b0}}, volts_reg[SPLIT_W-1:0]};
        hi_x  = {{(DUTY_W-(VOLT_W-SPLIT_W)){volts_reg[VOLT_W-1]}},
                 volts_reg[VOLT_W-1:SPLIT_W]};
        inv_x = {{(DUTY_W-16){1'b0}}, cfg.inv_supply};
    end

    // magnitude, round half up, saturate, cap
    logic                        neg;
    logic [DUTY_W-1:0]           mag;
    logic [DUTY_W-1:0]           rnd;
    logic [DUTY_W-FRAC_SH-1:0]   quot;
    logic [15:0]                 sat;
    logic [15:0]                 duty_mag_next;

    always_comb
    begin
        neg  = duty_reg[DUTY_W-1];
        mag  = neg ? DUTY_W'(-duty_reg) : DUTY_W'(duty_reg);
        rnd  = mag + (DUTY_W'(1) << (FRAC_SH - 1));
        quot = rnd[DUTY_W-1:FRAC_SH];
        sat  = (|quot[DUTY_W-FRAC_SH-1:16]) ? 16'hFFFF : quot[15:0];
        duty_mag_next = (sat > duty_cap) ? duty_cap : sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (ctrl.step)
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            meas_s0_reg  <= meas_current;
            want_s0_reg  <= want_current;
            speed_s0_reg <= speed;

            err_s1_reg   <= err_s0;
            want_s1_reg  <= want_s0_reg;
            speed_s1_reg <= speed_s0_reg;

            // integ_reg still holds this item's clamped sum here
            prod_res_reg <= res_x * want_x;
            prod_kt_reg  <= kt_x * speed_x;
            prod_p_reg   <= kp_x * err_x;
            prod_i_reg   <= ki_x * integ_x;

            volts_reg    <= volts_next;

            pp_lo_reg    <= lo_x * inv_x;
            pp_hi_reg    <= hi_x * inv_x;

            duty_reg     <= (pp_hi_reg <<< SPLIT_W) + pp_lo_reg;

            duty_mag_reg <= duty_mag_next;
            reverse_reg  <= neg;
        end
    end

    assign duty_mag = duty_mag_reg;
    assign reverse  = reverse_reg;

endmodule

// ----- hdl/dual_pi_current_loop_unit.sv -----
// top level of the dual pi current loop: handshake, pipeline valid tracking,
// config registers and the two channel datapaths; depends on dpcl_pkg
`timescale 1ns / 1ps

// Two-channel PI motor current controller with integrator clamp and
// resistance / back-emf feedforward. One sample for both motors is taken per
// transfer and one result comes back per sample, in order. The block takes a
// new sample every cycle unless the output stalls; a sample passes the input
// register, error and integrator, products, voltage sum, duty partial
// products, duty sum and output register. The integrator feedback is one add
// and clamp, so it never limits the rate. A stall on the output freezes the
// whole pipeline and shows up on in_stall in the same cycle. Writes to
// indexes above 7 are dropped. Configuration is written through cfg_wr_en /
// cfg_index / cfg_data while no sample is in flight; the user must ensure it.

module dual_pi_current_loop_unit
    import dpcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [15:0]    meas_current_a,
    input  logic signed [15:0]    want_current_a,
    input  logic signed [15:0]    speed_a,
    input  logic signed [15:0]    meas_current_b,
    input  logic signed [15:0]    want_current_b,
    input  logic signed [15:0]    speed_b,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           duty_mag_a,
    output logic                  reverse_a,
    output logic [15:0]           duty_mag_b,
    output logic                  reverse_b
);

    cfg_t       cfg;
    pipe_ctrl_t ctrl;

    logic              adv;
    logic              accept;
    logic [STAGES-1:0] pipe_v_reg;
    logic [STAGES-1:0] pipe_v_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign accept    = in_valid && adv;
    assign ctrl.adv  = adv;
    assign ctrl.step = pipe_v_reg[0] && adv;

    always_comb
    begin
        pipe_v_next    = pipe_v_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            pipe_v_next    = {pipe_v_reg[STAGES-2:0], accept};
            out_valid_next = pipe_v_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_v_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_v_reg    <= pipe_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    dpcl_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dpcl_channel u_chan_a (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg          (cfg),
        .duty_cap     (cfg.duty_cap_a),
        .meas_current (meas_current_a),
        .want_current (want_current_a),
        .speed        (speed_a),
        .duty_mag     (duty_mag_a),
        .reverse      (reverse_a)
    );

    dpcl_channel u_chan_b (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg          (cfg),
        .duty_cap     (cfg.duty_cap_b),
        .meas_current (meas_current_b),
        .want_current (want_current_b),
        .speed        (speed_b),
        .duty_mag     (duty_mag_b),
        .reverse      (reverse_b)
    );

`ifndef SYNTH
    // every transfer in enters the first pipeline rank
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> pipe_v_reg[0])
        else $error("accepted sample did not enter the pipeline");

    // a stalled result freezes everything in flight
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(pipe_v_reg) && out_valid))
        else $error("pipeline moved while the output was stalled");

    // a result only appears when the last rank held an item
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pipe_v_reg[STAGES-1]))
        else $error("result valid without an item in the last rank");

    // shown duty never exceeds the channel cap
    a_duty_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_mag_a <= cfg.duty_cap_a && duty_mag_b <= cfg.duty_cap_b))
        else $error("duty magnitude above its cap");
`endif

endmodule

// ----- test/dual_pi_current_loop_unit_test.sv -----
// self-checking testbench for the dual pi current loop unit
// predicts duty and direction per sample and checks every output transfer; needs dpcl_pkg
`timescale 1ns / 1ps

module dual_pi_current_loop_unit_test;
    import dpcl_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_INV_SUPPLY + 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    typedef struct {
        logic signed [15:0] meas_a;
        logic signed [15:0] want_a;
        logic signed [15:0] speed_a;
        logic signed [15:0] meas_b;
        logic signed [15:0] want_b;
        logic signed [15:0] speed_b;
    } sample_t;

    typedef struct {
        logic [15:0] mag_a;
        logic        rev_a;
        logic [15:0] mag_b;
        logic        rev_b;
    } duty_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [15:0]    meas_current_a;
    logic signed [15:0]    want_current_a;
    logic signed [15:0]    speed_a;
    logic signed [15:0]    meas_current_b;
    logic signed [15:0]    want_current_b;
    logic signed [15:0]    speed_b;
    logic                  out_valid;
    logic                  out_stall;
    logic [15:0]           duty_mag_a;
    logic                  reverse_a;
    logic [15:0]           duty_mag_b;
    logic                  reverse_b;

    cfg_t               shadow_cfg;
    logic signed [15:0] integ_acc_a;
    logic signed [15:0] integ_acc_b;
    duty_t              pending_duty[$];

    int error_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    dual_pi_current_loop_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .meas_current_a (meas_current_a),
        .want_current_a (want_current_a),
        .speed_a        (speed_a),
        .meas_current_b (meas_current_b),
        .want_current_b (want_current_b),
        .speed_b        (speed_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duty_mag_a     (duty_mag_a),
        .reverse_a      (reverse_a),
        .duty_mag_b     (duty_mag_b),
        .reverse_b      (reverse_b)
    );

    always #5 clk = ~clk;

    // one channel of the controller: integrator update, feedforward plus pi, duty scaling
    function automatic void pi_channel(
        input  logic signed [15:0] meas,
        input  logic signed [15:0] want,
        input  logic signed [15:0] speed,
        input  logic signed [15:0] integ,
        input  logic        [15:0] cap,
        output logic signed [15:0] integ_next,
        output logic        [15:0] mag,
        output logic               rev
    );
        logic signed [16:0] err;
        longint             acc;
        longint             lim;
        longint             volts;
        longint             duty;
        longint unsigned    absd;
        longint unsigned    rounded;
        err = want - meas;
        lim = longint'(shadow_cfg.integ_limit);
        acc = longint'(integ) + longint'(err);
        if (acc > lim)
            acc = lim;
        if (acc < -lim)
            acc = -lim;
        integ_next = acc[15:0];
        volts = longint'(shadow_cfg.winding_resistance) * longint'(want)
              + longint'(shadow_cfg.torque_constant) * longint'(speed)
              + longint'(shadow_cfg.prop_gain) * longint'(err)
              + longint'(shadow_cfg.integ_gain) * acc;
        duty = volts * longint'(shadow_cfg.inv_supply);
        rev = (duty < 0);
        absd = rev ? longint'(-duty) : longint'(duty);
        // round half up from q.36 to q0.16, then saturate and cap
        rounded = (absd + (64'd1 << (FRAC_SH - 1))) >> FRAC_SH;
        if (rounded > 64'd65535)
            rounded = 64'd65535;
        if (rounded > longint'(cap))
            rounded = longint'(cap);
        mag = rounded[15:0];
    endfunction

    function automatic duty_t predict_duty(input sample_t s);
        duty_t              d;
        logic signed [15:0] nxt;
        pi_channel(s.meas_a, s.want_a, s.speed_a, integ_acc_a, shadow_cfg.duty_cap_a,
                   nxt, d.mag_a, d.rev_a);
        integ_acc_a = nxt;
        pi_channel(s.meas_b, s.want_b, s.speed_b, integ_acc_b, shadow_cfg.duty_cap_b,
                   nxt, d.mag_b, d.rev_b);
        integ_acc_b = nxt;
        return d;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        duty_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_duty.size() == 0)
            begin
                $display("%0t ns: unexpected result, duty_mag_a %0d duty_mag_b %0d",
                         $time, duty_mag_a, duty_mag_b);
                error_count++;
            end
            else
            begin
                e = pending_duty.pop_front();
                check_field("duty_mag_a", e.mag_a, duty_mag_a);
                check_field("reverse_a", e.rev_a, reverse_a);
                check_field("duty_mag_b", e.mag_b, duty_mag_b);
                check_field("reverse_b", e.rev_b, reverse_b);
            end
        end
    end

    // receiver side: random stall, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_sample(input sample_t s);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        meas_current_a <= s.meas_a;
        want_current_a <= s.want_a;
        speed_a        <= s.speed_a;
        meas_current_b <= s.meas_b;
        want_current_b <= s.want_b;
        speed_b        <= s.speed_b;
        do
            @(posedge clk);
        while (in_stall);
        pending_duty.push_back(predict_duty(s));
    endtask

    task automatic send_pair(input logic signed [15:0] ma, wa, sa, mb, wb, sb);
        sample_t s;
        s.meas_a  = ma;
        s.want_a  = wa;
        s.speed_a = sa;
        s.meas_b  = mb;
        s.want_b  = wb;
        s.speed_b = sb;
        send_sample(s);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_duty.size() != 0)
            @(posedge clk);
        repeat (STAGES + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        wait_drained();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PROP_GAIN:   shadow_cfg.prop_gain          = data;
            REG_INTEG_GAIN:  shadow_cfg.integ_gain         = data;
            REG_INTEG_LIMIT: shadow_cfg.integ_limit        = data[14:0];
            REG_DUTY_CAP_A:  shadow_cfg.duty_cap_a         = data;
            REG_DUTY_CAP_B:  shadow_cfg.duty_cap_b         = data;
            REG_WINDING_RES: shadow_cfg.winding_resistance = data;
            REG_TORQUE_K:    shadow_cfg.torque_constant    = data;
            REG_INV_SUPPLY:  shadow_cfg.inv_supply         = data;
            default: ;
        endcase
    endtask

    task automatic load_registers(input logic [15:0] kp, ki, lim, cap_a, cap_b, res, kt, inv);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_INTEG_LIMIT, lim);
        write_reg(REG_DUTY_CAP_A, cap_a);
        write_reg(REG_DUTY_CAP_B, cap_b);
        write_reg(REG_WINDING_RES, res);
        write_reg(REG_TORQUE_K, kt);
        write_reg(REG_INV_SUPPLY, inv);
    endtask

    function automatic logic [15:0] rand_reg(input int unsigned typical);
        case ($urandom_range(7))
            0:       return '0;
            1:       return 16'hffff;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(typical));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_current();
        case ($urandom_range(9))
            0, 1, 2: return 16'($urandom);
            7:       return 16'sh8000;
            8:       return 16'sh7fff;
            9:       return '0;
            default: return 16'(int'($urandom_range(4096)) - 2048);
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.want_a  = rand_current();
        s.speed_a = rand_current();
        s.want_b  = rand_current();
        s.speed_b = rand_current();
        // mostly a tracking loop: measurement near the setpoint
        if ($urandom_range(99) < 60)
            s.meas_a = s.want_a + 16'($urandom_range(512)) - 16'd256;
        else
            s.meas_a = rand_current();
        if ($urandom_range(99) < 60)
            s.meas_b = s.want_b + 16'($urandom_range(512)) - 16'd256;
        else
            s.meas_b = rand_current();
        return s;
    endfunction

    task automatic randomize_registers();
        load_registers(rand_reg(1024), rand_reg(256), rand_reg(16384),
                       $urandom_range(1) ? 16'hffff : rand_reg(65535),
                       $urandom_range(1) ? 16'hffff : rand_reg(65535),
                       rand_reg(1024), rand_reg(2048), rand_reg(16384));
    endtask

    // reset values: zero, opposite full-scale errors, integrator pinned at both clamps
    task automatic test_reset_defaults();
        send_gap_pct   = 20;
        recv_stall_pct = 20;
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_pair(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_pair(0, 100, 0, 0, -100, 0);
    endtask

    // unit supply reciprocal exposes rounding and sign of tiny duties
    task automatic test_rounding_and_direction();
        load_registers(16'd0, 16'd0, 16'd12288, 16'hffff, 16'hffff, 16'd512, 16'd737, 16'd1);
        send_pair(0, 0, -1, 0, 0, 1);                     // reverse set with zero magnitude
        send_pair(1024, 1024, 0, 1023, 1023, 0);          // exactly half rounds up, below does not
        send_pair(-1024, -1024, 0, -1023, -1023, 0);
        write_reg(REG_INV_SUPPLY, 16'd0);                 // zero reciprocal gives zero duty
        send_pair(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_pair(0, -5, -7, 0, 5, 7);
        // writes above the last register must not land anywhere
        write_reg(REG_FIRST_UNUSED, 16'hffff);
        write_reg(REG_LAST_UNUSED, 16'hffff);
        send_pair(0, 300, 300, 0, -300, -300);
    endtask

    task automatic test_gains_and_caps();
        // full-scale everything, limit written with bit 15 set, cap a at zero
        load_registers(16'hffff, 16'hffff, 16'hffff, 16'd0, 16'd1000,
                       16'hffff, 16'hffff, 16'hffff);
        send_pair(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_pair(0, 3, 1, 0, -3, -1);
        send_pair(2, 0, 0, -2, 0, 0);
        // zero clamp holds the integrator at zero
        load_registers(16'd0, 16'd256, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'd4096);
        send_pair(0, 4000, 0, 0, -4000, 0);
        send_pair(0, 16'sh7fff, 0, 16'sh7fff, 16'sh8000, 0);
        // small clamp: wind up, hold, then unwind
        write_reg(REG_INTEG_LIMIT, 16'd5);
        write_reg(REG_INTEG_GAIN, 16'hffff);
        send_pair(0, 2, 0, 0, -2, 0);
        send_pair(0, 2, 0, 0, -2, 0);
        send_pair(0, 2, 0, 0, -2, 0);
        send_pair(0, -4, 0, 0, 4, 0);
        send_pair(0, -9, 0, 0, 9, 0);
    endtask

    task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
        int done;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < count)
        begin
            randomize_registers();
            repeat (80)
            begin
                send_sample(random_sample());
                done++;
            end
        end
    endtask

    // receiver holds off while the sender keeps offering, so the pipeline fills up
    task automatic test_backpressure();
        wait_drained();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_req       = 200;
        repeat (40)
            send_sample(random_sample());
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_drain_pause();
        send_gap_pct   = 30;
        recv_stall_pct = 30;
        repeat (15)
            send_sample(random_sample());
        wait_drained();
        repeat (15)
            send_sample(random_sample());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        meas_current_a = '0;
        want_current_a = '0;
        speed_a        = '0;
        meas_current_b = '0;
        want_current_b = '0;
        speed_b        = '0;

        shadow_cfg.prop_gain          = RST_PROP_GAIN;
        shadow_cfg.integ_gain         = RST_INTEG_GAIN;
        shadow_cfg.integ_limit        = RST_INTEG_LIMIT;
        shadow_cfg.duty_cap_a         = RST_DUTY_CAP;
        shadow_cfg.duty_cap_b         = RST_DUTY_CAP;
        shadow_cfg.winding_resistance = RST_WINDING_RES;
        shadow_cfg.torque_constant    = RST_TORQUE_K;
        shadow_cfg.inv_supply         = RST_INV_SUPPLY;
        integ_acc_a = '0;
        integ_acc_b = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_rounding_and_direction();
        test_gains_and_caps();
        test_random_traffic(530, 29, 51);
        test_random_traffic(530, 51, 29);
        test_random_traffic(530, 0, 0);
        test_backpressure();
        test_drain_pause();

        wait_drained();
        repeat (STAGES + 4) @(posedge clk);
        if (error_count == 0 && pending_duty.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/dpcl_pkg.sv
hdl/dpcl_regs.sv
hdl/dpcl_channel.sv
hdl/dual_pi_current_loop_unit.sv
test/dual_pi_current_loop_unit_test.sv
